// ===== hw/rtl/lfukvc_pkg.sv =====
// Shared types and constants for the LFU key-value cache.
package lfukvc_pkg;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_CAPACITY_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] lookup_key;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } out_item_t;

endpackage

// ===== hw/rtl/lfu_key_value_cache_unit.sv =====
// Fully associative key-value cache with LFU replacement and LRU tiebreak.
//
// Takes one get or put transaction per cycle and returns exactly one result for each.
// A transaction is registered at acceptance. In the next cycle, one combinational pass over
// the flat table does three things: the parallel key compare, the min-count/oldest victim
// select (a log2(CAPACITY) deep compare tree) and the count/rank update. The result then
// lands in the output register. The sustained rate is one transaction per cycle while
// out_stall is low. When the output register is stalled, the input register holds and
// in_stall rises. The table is cleared at reset by per-entry valid bits, so no clearing
// pass is needed. Capacity is set through cfg_wr_data. Values above CAPACITY act as
// CAPACITY. Zero makes puts change nothing.
module lfu_key_value_cache_unit #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lfukvc_pkg::in_item_t            in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lfukvc_pkg::out_item_t           out_item,
  input  logic                            cfg_wr_en,
  input  logic [lfukvc_pkg::CFG_W-1:0]    cfg_wr_data
);
  import lfukvc_pkg::*;

  localparam int KW        = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_BITS  = RANK_BITS;
  localparam int NLEAF     = 1 << IDX_BITS;
  localparam int OCC_BITS  = $clog2(CAPACITY + 1);
  localparam int CAP_W     = (OCC_BITS > CFG_W) ? OCC_BITS : CFG_W;
  localparam int VKEY_W    = 1 + COUNT_BITS + RANK_BITS;

  // table state
  logic [CAPACITY-1:0]   valid_r;
  logic [KW-1:0]         key_r   [CAPACITY];
  logic [31:0]           value_r [CAPACITY];
  logic [COUNT_BITS-1:0] count_r [CAPACITY];
  logic [RANK_BITS-1:0]  rank_r  [CAPACITY];
  logic [OCC_BITS-1:0]   occ_r;
  logic [CFG_W-1:0]      cap_r;

  // pipeline registers
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic advance;
  logic in_accept;

  logic [KW-1:0]        cur_key;
  logic [CAPACITY-1:0]  match_vec;
  logic                 hit;
  logic [IDX_BITS-1:0]  found_idx;
  logic [IDX_BITS-1:0]  free_idx;
  logic [IDX_BITS-1:0]  victim_idx;
  logic                 victim_ok;
  logic [CAP_W-1:0]     cap_eff;
  logic                 full;
  logic                 is_put;
  logic                 do_touch;
  logic                 do_insert;
  logic                 do_fill;
  logic [IDX_BITS-1:0]  slot;
  logic [RANK_BITS:0]   old_rank;
  logic [31:0]          hit_value;

  logic [VKEY_W-1:0]    tkey [2*NLEAF];
  logic [IDX_BITS-1:0]  tidx [2*NLEAF];

  logic [COUNT_BITS-1:0] count_nxt [CAPACITY];
  logic [RANK_BITS-1:0]  rank_nxt  [CAPACITY];
  logic [OCC_BITS-1:0]   occ_nxt;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cur_key = s1_item_r.lookup_key[KW-1:0];
  assign is_put  = (s1_item_r.opcode == OP_PUT);

  // key compare, hit select, first free slot
  always_comb begin
    match_vec = '0;
    found_idx = '0;
    free_idx  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = valid_r[i] && (key_r[i] == cur_key);
      if (match_vec[i]) begin
        found_idx = IDX_BITS'(i);
        hit_value = value_r[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign hit = |match_vec;

  // victim: lowest count, then highest rank (oldest); lower index wins a full tie
  always_comb begin
    tkey[0] = '0;
    tidx[0] = '0;
    for (int n = 0; n < NLEAF; n++) begin
      if (n < CAPACITY) begin
        tkey[NLEAF+n] = {!valid_r[n], count_r[n], ~rank_r[n]};
      end else begin
        tkey[NLEAF+n] = '1;
      end
      tidx[NLEAF+n] = IDX_BITS'(n);
    end
    for (int n = NLEAF - 1; n >= 1; n--) begin
      if (tkey[2*n+1] < tkey[2*n]) begin
        tkey[n] = tkey[2*n+1];
        tidx[n] = tidx[2*n+1];
      end else begin
        tkey[n] = tkey[2*n];
        tidx[n] = tidx[2*n];
      end
    end
  end

  assign victim_idx = tidx[1];
  assign victim_ok  = !tkey[1][VKEY_W-1];

  always_comb begin
    logic [CAP_W-1:0] cfg_ext;
    logic [CAP_W-1:0] cap_lim;
    cfg_ext = CAP_W'(cap_r);
    cap_lim = CAP_W'(CAPACITY);
    cap_eff = (cfg_ext > cap_lim) ? cap_lim : cfg_ext;
    full    = (CAP_W'(occ_r) >= cap_eff);
  end

  // decide the update for this transaction
  always_comb begin
    do_touch  = 1'b0;
    do_insert = 1'b0;
    do_fill   = 1'b0;
    slot      = found_idx;
    if (s1_valid_r) begin
      if (hit && (!is_put || cap_eff != '0)) begin
        do_touch = 1'b1;
      end else if (!hit && is_put && cap_eff != '0) begin
        if (full) begin
          do_insert = victim_ok;
          slot      = victim_idx;
        end else begin
          do_insert = 1'b1;
          do_fill   = 1'b1;
          slot      = free_idx;
        end
      end
    end
    old_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot == IDX_BITS'(i)) begin
        old_rank = {1'b0, rank_r[i]};
      end
    end
    if (do_fill) begin
      old_rank = (RANK_BITS+1)'(CAPACITY);
    end
  end

  // new counts and ranks
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      count_nxt[i] = count_r[i];
      rank_nxt[i]  = rank_r[i];
      if ((do_touch || do_insert) && slot == IDX_BITS'(i)) begin
        rank_nxt[i] = '0;
        if (do_insert) begin
          count_nxt[i] = COUNT_BITS'(1);
        end else if (count_r[i] != '1) begin
          count_nxt[i] = count_r[i] + COUNT_BITS'(1);
        end
      end else if ((do_touch || do_insert) && valid_r[i] &&
                   ({1'b0, rank_r[i]} < old_rank)) begin
        rank_nxt[i] = rank_r[i] + RANK_BITS'(1);
      end
    end
    occ_nxt = do_fill ? occ_r + OCC_BITS'(1) : occ_r;
  end

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);
    out_item_nxt.hit        = hit;
    out_item_nxt.read_value = (!is_put && hit) ? hit_value : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= CFG_CAPACITY_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
        count_r[i] <= '0;
        rank_r[i]  <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (advance) begin
        occ_r <= occ_nxt;
        for (int i = 0; i < CAPACITY; i++) begin
          count_r[i] <= count_nxt[i];
          rank_r[i]  <= rank_nxt[i];
          if (do_insert && slot == IDX_BITS'(i)) begin
            valid_r[i] <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        if ((do_insert || (do_touch && is_put)) && slot == IDX_BITS'(i)) begin
          value_r[i] <= s1_item_r.write_value;
        end
        if (do_insert && slot == IDX_BITS'(i)) begin
          key_r[i] <= cur_key;
        end
      end
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match number of valid entries");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= CAPACITY)
    else $error("occupancy above capacity");

  a_occ_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> occ_r >= $past(occ_r))
    else $error("occupancy decreased");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("held transaction lost or changed");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && is_put && !hit && cap_eff != '0) |-> (do_fill || victim_ok))
    else $error("put of new key found no slot");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the LFU key-value cache unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfukvc_pkg::*;

  localparam int CAP_MAX = 16;
  localparam bit [15:0] USES_MAX = 16'hFFFF;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES = 11;
  localparam int NUM_ROWS = 31;
  localparam int POOL_SIZE = 20;
  localparam int MAX_PRINTS = 50;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    int               reps;
    logic [CFG_W-1:0] cap;
    logic             op;
    logic [31:0]      key;
    logic [31:0]      value;
    bit               typed;
    logic             hit;
    logic [31:0]      rdata;
  } script_row_t;

  typedef struct {
    bit        given;
    out_item_t value;
  } scripted_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  lfu_key_value_cache_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Directed script; rows with typed set carry an expectation readable by eye.
  script_row_t script [NUM_ROWS] = '{
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h0000_0000, 32'h0,         1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0,         1'b1, 1'b0, 32'h0},
    '{ROW_CFG,  1,     5'd2,  OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h0000_0000, 32'h0F0F_0F0F, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // both counts end equal; the older of the two tied entries must go next
    '{ROW_ITEM, 4,     5'd0,  OP_GET, 32'h0000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 4,     5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h1234_5678, 32'h1,         1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h0000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  1,     5'd16, OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h0000_0000, 32'h0,         1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h0000_0000, 32'h0,         1'b1, 1'b1, 32'h1234_5678},
    // capacity below occupancy: entries stay, a new key replaces one victim
    '{ROW_CFG,  1,     5'd1,  OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h8000_0000, 32'h1,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h1234_5678, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h8000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
    // zero capacity: puts change nothing, gets still see old entries
    '{ROW_CFG,  1,     5'd0,  OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h5555_5555, 32'h0,         1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h0000_0000, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h0000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
    // oversize setting acts as full capacity
    '{ROW_CFG,  1,     5'd31, OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'hAAAA_AAAA, 32'h0,         1'b1, 1'b1, 32'h5555_5555},
    '{ROW_CFG,  1,     5'd2,  OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_PUT, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'h8000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 1,     5'd0,  OP_GET, 32'hAAAA_AAAA, 32'h0,         1'b0, 1'b0, 32'h0}
  };

  logic [CFG_W-1:0] phase_caps [NUM_PHASES] = '{
    5'd16, 5'd31, 5'd0, 5'd1, 5'd4, 5'd17, 5'd3, 5'd8, 5'd2, 5'd16, 5'd31
  };

  // cache image: one line per table entry
  bit               line_used  [CAP_MAX];
  bit [31:0]        line_key   [CAP_MAX];
  bit [31:0]        line_value [CAP_MAX];
  bit [15:0]        line_uses  [CAP_MAX];
  int unsigned      line_age   [CAP_MAX];
  int unsigned      line_fill = 0;
  logic [CFG_W-1:0] cap_setting = CFG_CAPACITY_RESET;

  out_item_t   expected_results [$];
  scripted_t   scripted_results [$];
  bit [31:0]   key_pool [POOL_SIZE];

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_request = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int stuck_cycles = 0;

  function automatic void make_youngest(int s, int unsigned old_age);
    for (int i = 0; i < CAP_MAX; i++) begin
      if (i != s && line_used[i] && line_age[i] < old_age) line_age[i]++;
    end
    line_age[s] = 0;
  endfunction

  function automatic void count_use(int s);
    if (line_uses[s] != USES_MAX) line_uses[s]++;
    make_youngest(s, line_age[s]);
  endfunction

  function automatic out_item_t cache_access(in_item_t req);
    out_item_t   res;
    int          hit_slot;
    int          slot;
    int unsigned limit;
    int unsigned old_age;
    hit_slot = -1;
    slot = -1;
    for (int i = 0; i < CAP_MAX; i++) begin
      if (line_used[i] && line_key[i] == req.lookup_key) hit_slot = i;
    end
    res.hit = (hit_slot >= 0);
    res.read_value = '0;
    limit = (cap_setting > CAP_MAX) ? CAP_MAX : cap_setting;
    if (req.opcode == OP_GET) begin
      if (hit_slot >= 0) begin
        res.read_value = line_value[hit_slot];
        count_use(hit_slot);
      end
    end else if (limit != 0) begin
      if (hit_slot >= 0) begin
        line_value[hit_slot] = req.write_value;
        count_use(hit_slot);
      end else begin
        if (line_fill >= limit) begin
          // lowest count wins, oldest among equal counts
          for (int i = 0; i < CAP_MAX; i++) begin
            if (line_used[i] && (slot < 0 || line_uses[i] < line_uses[slot] ||
                (line_uses[i] == line_uses[slot] && line_age[i] > line_age[slot])))
              slot = i;
          end
          old_age = line_age[slot];
        end else begin
          for (int i = 0; i < CAP_MAX; i++) begin
            if (!line_used[i] && slot < 0) slot = i;
          end
          old_age = CAP_MAX;
          line_fill++;
        end
        line_used[slot] = 1'b1;
        line_key[slot] = req.lookup_key;
        line_value[slot] = req.write_value;
        line_uses[slot] = 16'd1;
        make_youngest(slot, old_age);
      end
    end
    return res;
  endfunction

  function automatic in_item_t random_item();
    in_item_t req;
    req.opcode = $urandom_range(0, 1) ? OP_PUT : OP_GET;
    // skewed pick so a few keys run up high counts
    if ($urandom_range(0, 99) < 85)
      req.lookup_key = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
    else
      req.lookup_key = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        req.write_value = '0;
      end
      1: begin
        req.write_value = '1;
      end
      default: begin
        req.write_value = $urandom;
      end
    endcase
    return req;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("testbench: mismatch on %s at result %0d: got %h, want %h",
               field, results_checked, got, want);
    mismatches++;
  endtask

  task automatic send_item(in_item_t req, bit given, out_item_t want);
    int        gap;
    scripted_t s;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    s.given = given;
    s.value = want;
    scripted_results.push_back(s);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] cap);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) cap_setting = cfg_wr_data;
  end

  always @(posedge clk) begin : accept_request
    out_item_t model;
    scripted_t s;
    if (rst_n && in_valid && !in_stall) begin
      model = cache_access(in_item);
      s = scripted_results.pop_front();
      expected_results.push_back(s.given ? s.value : model);
      items_sent++;
    end
  end

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_item.read_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.hit !== want.hit)
          report_mismatch("hit", 32'(out_item.hit), 32'(want.hit));
        if (out_item.read_value !== want.read_value)
          report_mismatch("read_value", out_item.read_value, want.read_value);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("testbench: no progress for %0d cycles", IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side: per-transaction stall, plus one long hold on request
  initial begin : result_sink
    int stall_n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall_n = rx_quiet ? 0 : $urandom_range(0, 19);
      if (hold_request) begin
        stall_n = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    in_item_t  req;
    out_item_t want;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (script[r].kind == ROW_CFG) begin
        set_capacity(script[r].cap);
      end else begin
        req.opcode = script[r].op;
        req.lookup_key = script[r].key;
        req.write_value = script[r].value;
        want.hit = script[r].hit;
        want.read_value = script[r].rdata;
        tx_quiet = (script[r].reps > 1);
        rx_quiet = tx_quiet;
        repeat (script[r].reps) send_item(req, script[r].typed, want);
      end
    end

    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    want = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_caps[p]);
      repeat (3) key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
      // near-miss key: one bit away from a live one
      key_pool[$urandom_range(2, POOL_SIZE - 1)] =
        key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'd1 << $urandom_range(0, 31));
      tx_quiet = (p % 3 == 2);
      rx_quiet = (p % 4 == 3);
      if (p == 1) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, want);
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("testbench: %0d transactions sent, %0d results compared, %0d capacity writes",
             items_sent, results_checked, cfg_writes);
    $display("testbench: tied counts, zero/oversize/shrunk capacity, %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
